// ----- sv/mmstr_pkg.sv -----
// mmstr_pkg: shared types, constants and the interpolator coefficient rule
// for the Mueller-Muller symbol timing recovery block.
// Depends on nothing; the configuration interface, intake, symbol engine and top level import it.
package mmstr_pkg;

  // Fixed field widths
  localparam int OMEGA_W     = 20;
  localparam int GAIN_W      = 16;
  localparam int PHASE_W     = 16;
  localparam int SKIP_W      = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  // Interpolator arithmetic: coefficients are Q15, with headroom for overshoot
  localparam int COEF_W     = 18;
  localparam int COEF_FRAC  = 15;
  localparam int ROUND_HALF = 16384;

  // Loop arithmetic width (omega, deviation and phase sums, signed)
  localparam int LOOP_W = 23;

  // Symbols per input sample before a zero skip is forced to one
  localparam int MAX_RUN = 4;
  localparam int RUN_W   = 3;

  // Queue depths
  localparam int QUEUE_DEPTH = 2;
  localparam int RES_DEPTH   = 2;

  // Magnitude bits covered by the elaboration-time divider
  localparam int DIV_BITS = 48;

  // Register reset values
  localparam logic [OMEGA_W-1:0] NOMINAL_OMEGA_RST = 20'd131072;
  localparam logic [GAIN_W-1:0]  OMEGA_GAIN_RST    = 16'd16;
  localparam logic [GAIN_W-1:0]  PHASE_GAIN_RST    = 16'd1966;
  localparam logic [GAIN_W-1:0]  OMEGA_LIMIT_RST   = 16'd328;
  localparam logic [PHASE_W-1:0] INITIAL_PHASE_RST = 16'd32768;
  localparam logic [OMEGA_W-1:0] OMEGA_MAX         = 20'hFFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NOMINAL_OMEGA = 3'd0,
    REG_OMEGA_GAIN    = 3'd1,
    REG_PHASE_GAIN    = 3'd2,
    REG_OMEGA_LIMIT   = 3'd3,
    REG_INITIAL_PHASE = 3'd4
  } mmstr_reg_t;

  typedef struct packed {
    logic [OMEGA_W-1:0] nominal_omega;
    logic [GAIN_W-1:0]  omega_gain;
    logic [GAIN_W-1:0]  phase_gain;
    logic [GAIN_W-1:0]  omega_limit;
  } mmstr_cfg_t;

  // End-of-run report from the symbol engine back to the intake
  typedef struct packed {
    logic              valid;
    logic [SKIP_W-1:0] skip;
  } mmstr_done_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_COEF,
    ST_MAC,
    ST_RND,
    ST_ERR,
    ST_GAIN,
    ST_OMEGA,
    ST_CLIP,
    ST_PHASE,
    ST_EMIT
  } mmstr_state_t;

  // Signed quotient truncated toward zero, by shift and subtract on magnitudes
  function automatic longint div_trunc(longint a, longint b);
    longint ua;
    longint ub;
    longint q;
    longint r;
    logic   neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    q   = 0;
    r   = 0;
    for (int i = DIV_BITS - 1; i >= 0; i--) begin
      r = (r <<< 1) | ((ua >>> i) & longint'(1));
      q = q <<< 1;
      if (r >= ub) begin
        r = r - ub;
        q = q | longint'(1);
      end
    end
    return neg ? -q : q;
  endfunction

  // Lagrange (maximally flat) interpolator coefficient for phase row p, tap k.
  // Q30 products truncated toward zero, result truncated to Q15.
  function automatic longint coef_calc(int p, int k, int taps, int phases);
    longint c;
    longint num;
    longint den;
    int     ctr;
    c   = longint'(1) <<< 30;
    ctr = (taps - 1) >>> 1;
    for (int m = 0; m < taps; m++) begin
      if (m != k) begin
        num = longint'(p) - longint'(m - ctr) * longint'(phases);
        den = longint'(k - m) * longint'(phases);
        c   = div_trunc(c * num, den);
      end
    end
    return div_trunc(c, longint'(32768));
  endfunction

endpackage

// ----- sv/mmstr_in_if.sv -----
// mmstr_in_if: sample input channel (valid/ready plus one signed sample).
// Depends on nothing.
interface mmstr_in_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- sv/mmstr_out_if.sv -----
// mmstr_out_if: symbol result channel (valid/ready, symbol and run marker).
// Depends on nothing.
interface mmstr_out_if #(parameter int SAMPLE_BITS = 16) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] symbol;
  logic                          last_of_run;

  modport source (output valid, output symbol, output last_of_run, input ready);
  modport sink   (input valid, input symbol, input last_of_run, output ready);
endinterface

// ----- sv/mmstr_cfg_if.sv -----
// mmstr_cfg_if: register write channel (valid/ready, index and data).
// Depends on mmstr_pkg for the index and data widths.
interface mmstr_cfg_if ();
  logic                               valid;
  logic                               ready;
  logic [mmstr_pkg::CFG_INDEX_W-1:0]  index;
  logic [mmstr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mmstr_fifo.sv -----
// mmstr_fifo: small register FIFO used for the job queue and the result queue.
// Depends on nothing.
module mmstr_fifo #(
  parameter int W     = 17,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/mmstr_front.sv -----
// mmstr_front: sample intake; runs the skip count and tags each sample as
// skip-only or symbol trigger. Depends on mmstr_pkg and mmstr_in_if.
module mmstr_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  mmstr_in_if.sink                in_chan,
  input  logic                    q_full,
  output logic                    q_push,
  output logic [SAMPLE_BITS:0]    q_wdata,
  input  mmstr_pkg::mmstr_done_t  done
);
  import mmstr_pkg::*;

  logic [SKIP_W-1:0] skip_r;
  logic [SKIP_W-1:0] skip_dec;
  logic              wait_r;
  logic              trigger;
  logic              accept;

  // Hold off after a trigger until the symbol engine hands back the new skip
  assign in_chan.ready = !wait_r && !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign skip_dec      = (skip_r != '0) ? skip_r - 1'b1 : '0;
  assign trigger       = (skip_dec == '0);
  assign q_push        = accept;
  assign q_wdata       = {trigger, in_chan.sample};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
      wait_r <= 1'b0;
    end else if (done.valid) begin
      skip_r <= done.skip;
      wait_r <= 1'b0;
    end else if (accept) begin
      skip_r <= skip_dec;
      wait_r <= trigger;
    end
  end

endmodule

// ----- sv/mmstr_back.sv -----
// mmstr_back: symbol engine; sample window, serial 1-multiplier interpolator,
// Mueller-Muller error and omega/mu loop. Depends on mmstr_pkg.
module mmstr_back #(
  parameter int TAPS        = 8,
  parameter int PHASES      = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mmstr_pkg::mmstr_cfg_t   cfg,
  input  logic                    q_empty,
  input  logic [SAMPLE_BITS:0]    q_rdata,
  output logic                    q_pop,
  input  logic                    res_full,
  output logic                    res_push,
  output logic [SAMPLE_BITS:0]    res_wdata,
  output mmstr_pkg::mmstr_done_t  done
);
  import mmstr_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int TW    = $clog2(TAPS);
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int RW    = $clog2(PHASES + 1);
  localparam int IW    = PHASE_W + RW + 1;
  localparam int PW    = COEF_W + SB;
  localparam int AW    = PW + $clog2(TAPS);
  localparam int EW    = SB + 2;
  localparam int GW    = GAIN_W + 1 + EW;
  localparam int AV_W  = LOOP_W - PHASE_W;

  mmstr_state_t state_r, state_nxt;

  // Coefficient tables, one per tap, row = phase
  logic signed [COEF_W-1:0] ctab [TAPS][PHASES+1];

  for (genvar gk = 0; gk < TAPS; gk++) begin : g_tap
    for (genvar gp = 0; gp <= PHASES; gp++) begin : g_ph
      localparam logic signed [COEF_W-1:0] CV =
        COEF_W'(coef_calc(gp, gk, TAPS, PHASES));
      assign ctab[gk][gp] = CV;
    end
  end

  // Loop state
  logic signed [SB-1:0]      win_r [TAPS];
  logic [OMEGA_W-1:0]        omega_now_r;
  logic [PHASE_W-1:0]        phase_frac_r;
  logic signed [SB-1:0]      prev_r;
  logic [CNT_W-1:0]          tap_r;
  logic [RUN_W-1:0]          run_r;

  // Per-symbol working registers
  logic [RW-1:0]             row_r;
  logic signed [COEF_W-1:0]  coef_row_r [TAPS];
  logic signed [PW-1:0]      prod_r;
  logic signed [AW-1:0]      acc_r;
  logic signed [SB-1:0]      sym_r;
  logic signed [EW-1:0]      err_r;
  logic signed [LOOP_W-1:0]  go_r;
  logic signed [LOOP_W-1:0]  gp_r;
  logic signed [LOOP_W-1:0]  dev_r;
  logic [AV_W-1:0]           adv_r;

  // Combinational helpers
  logic [IW-1:0]             row_sum;
  logic [IW-PHASE_W-1:0]     row_raw;
  logic [RW-1:0]             row_nxt;
  logic [TW-1:0]             tsel;
  logic signed [AW-1:0]      rnd_sum;
  logic signed [AW-1:0]      rnd_sh;
  logic signed [SB-1:0]      sym_nxt;
  logic signed [EW-1:0]      err_a;
  logic signed [EW-1:0]      err_b;
  logic signed [GW-1:0]      prod_o;
  logic signed [GW-1:0]      prod_p;
  logic signed [LOOP_W-1:0]  nom_ext;
  logic signed [LOOP_W-1:0]  lim_ext;
  logic signed [LOOP_W-1:0]  dev_clip;
  logic signed [LOOP_W-1:0]  om_sum;
  logic [OMEGA_W-1:0]        omega_nxt;
  logic signed [LOOP_W-1:0]  t_sum;
  logic signed [LOOP_W-1:0]  t_clamp;
  logic                      last;
  logic [SKIP_W-1:0]         skip_out;

  // Row of the coefficient table nearest to mu
  assign row_sum = IW'(phase_frac_r) * IW'(PHASES) + IW'(32768);
  assign row_raw = row_sum[IW-1:PHASE_W];
  assign row_nxt = (row_raw > (IW-PHASE_W)'(PHASES)) ? RW'(PHASES) : RW'(row_raw);

  assign tsel = (tap_r < CNT_W'(TAPS)) ? tap_r[TW-1:0] : '0;

  // Round to nearest, halves up, then saturate
  assign rnd_sum = acc_r + $signed(AW'(ROUND_HALF));
  assign rnd_sh  = rnd_sum >>> COEF_FRAC;
  always_comb begin
    if (rnd_sh > $signed({{(AW-SB){1'b0}}, 1'b0, {(SB-1){1'b1}}})) begin
      sym_nxt = {1'b0, {(SB-1){1'b1}}};
    end else if (rnd_sh < $signed({{(AW-SB){1'b1}}, 1'b1, {(SB-1){1'b0}}})) begin
      sym_nxt = {1'b1, {(SB-1){1'b0}}};
    end else begin
      sym_nxt = rnd_sh[SB-1:0];
    end
  end

  // Mueller-Muller error: sgn(prev)*sym - sgn(sym)*prev
  assign err_a = prev_r[SB-1] ? -EW'(sym_r) : EW'(sym_r);
  assign err_b = sym_r[SB-1] ? -EW'(prev_r) : EW'(prev_r);

  assign prod_o = $signed({1'b0, cfg.omega_gain}) * err_r;
  assign prod_p = $signed({1'b0, cfg.phase_gain}) * err_r;

  assign nom_ext = $signed({{(LOOP_W-OMEGA_W){1'b0}}, cfg.nominal_omega});
  assign lim_ext = $signed({{(LOOP_W-GAIN_W){1'b0}}, cfg.omega_limit});

  always_comb begin
    if (dev_r > lim_ext) begin
      dev_clip = lim_ext;
    end else if (dev_r < -lim_ext) begin
      dev_clip = -lim_ext;
    end else begin
      dev_clip = dev_r;
    end
    om_sum = nom_ext + dev_clip;
    if (om_sum < 0) begin
      omega_nxt = '0;
    end else if (om_sum > $signed({{(LOOP_W-OMEGA_W){1'b0}}, OMEGA_MAX})) begin
      omega_nxt = OMEGA_MAX;
    end else begin
      omega_nxt = om_sum[OMEGA_W-1:0];
    end
  end

  assign t_sum   = $signed({{(LOOP_W-PHASE_W){1'b0}}, phase_frac_r})
                 + $signed({{(LOOP_W-OMEGA_W){1'b0}}, omega_now_r}) + gp_r;
  assign t_clamp = (t_sum < 0) ? '0 : t_sum;

  assign last     = (adv_r != '0) || (run_r == RUN_W'(MAX_RUN));
  assign skip_out = (adv_r == '0) ? SKIP_W'(1) : adv_r[SKIP_W-1:0];

  assign res_wdata = {last, sym_r};

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    res_push  = 1'b0;
    done      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_rdata[SB]) begin
            state_nxt = ST_ROW;
          end
        end
      end
      ST_ROW:   state_nxt = ST_COEF;
      ST_COEF:  state_nxt = ST_MAC;
      ST_MAC: begin
        if (tap_r == CNT_W'(TAPS)) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND:   state_nxt = ST_ERR;
      ST_ERR:   state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_OMEGA;
      ST_OMEGA: state_nxt = ST_CLIP;
      ST_CLIP:  state_nxt = ST_PHASE;
      ST_PHASE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (last) begin
            done.valid = 1'b1;
            done.skip  = skip_out;
            state_nxt  = ST_IDLE;
          end else begin
            state_nxt = ST_ROW;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Loop state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
      omega_now_r  <= NOMINAL_OMEGA_RST;
      phase_frac_r <= INITIAL_PHASE_RST;
      prev_r       <= '0;
      tap_r        <= '0;
      run_r        <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            for (int i = 0; i < TAPS - 1; i++) begin
              win_r[i] <= win_r[i+1];
            end
            win_r[TAPS-1] <= q_rdata[SB-1:0];
            run_r         <= '0;
          end
        end
        ST_COEF:  tap_r <= '0;
        ST_MAC:   tap_r <= tap_r + 1'b1;
        ST_ERR:   prev_r <= sym_r;
        ST_CLIP:  omega_now_r <= omega_nxt;
        ST_PHASE: begin
          phase_frac_r <= t_clamp[PHASE_W-1:0];
          run_r        <= run_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_ROW: row_r <= row_nxt;
      ST_COEF: begin
        for (int i = 0; i < TAPS; i++) begin
          coef_row_r[i] <= ctab[i][row_r];
        end
        acc_r <= '0;
      end
      ST_MAC: begin
        prod_r <= coef_row_r[tsel] * win_r[tsel];
        if (tap_r != '0) begin
          acc_r <= acc_r + AW'(prod_r);
        end
      end
      ST_RND:   sym_r <= sym_nxt;
      ST_ERR:   err_r <= err_a - err_b;
      ST_GAIN: begin
        go_r <= LOOP_W'(prod_o >>> (SB - 1));
        gp_r <= LOOP_W'(prod_p >>> (SB - 1));
      end
      ST_OMEGA: dev_r <= $signed({{(LOOP_W-OMEGA_W){1'b0}}, omega_now_r}) + go_r - nom_ext;
      ST_PHASE: adv_r <= t_clamp[LOOP_W-1:PHASE_W];
      default: ;
    endcase
  end

endmodule

// ----- sv/mm_symbol_timing_recovery.sv -----
// mm_symbol_timing_recovery: Mueller-Muller symbol timing recovery, top level.
// Depends on mmstr_pkg, the three channel interfaces, mmstr_fifo,
// mmstr_front and mmstr_back.
//
//   channel    dir   payload                         transfer when
//   in_chan    in    sample                          valid && ready
//   out_chan   out   symbol, last_of_run             valid && ready
//   cfg_chan   in    index, data (register write)    valid && ready (always ready)
//
// A sample that only counts down the skip passes the intake and is popped by the
// symbol engine while idle; the intake takes such samples unless it is held after a
// trigger or the two-entry job queue is full.
// The engine computes a symbol serially: one tap per cycle through the single shared
// interpolator multiplier, then the serial loop update.
// After a sample that triggers symbols, input is held until the run ends and the
// engine hands back the next skip count.
// Synchronous active-low reset; no clearing pass, the block is ready right away.
module mm_symbol_timing_recovery #(
  parameter int TAPS        = 8,
  parameter int PHASES      = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  mmstr_in_if.sink     in_chan,
  mmstr_out_if.source  out_chan,
  mmstr_cfg_if.sink    cfg_chan
);
  import mmstr_pkg::*;

  // Configuration registers
  logic [OMEGA_W-1:0] nominal_omega_r;
  logic [GAIN_W-1:0]  omega_gain_r;
  logic [GAIN_W-1:0]  phase_gain_r;
  logic [GAIN_W-1:0]  omega_limit_r;
  mmstr_cfg_t         cfg;

  // Job queue between intake and symbol engine: {trigger, sample}
  logic                   q_push;
  logic [SAMPLE_BITS:0]   q_wdata;
  logic                   q_full;
  logic                   q_pop;
  logic [SAMPLE_BITS:0]   q_rdata;
  logic                   q_empty;

  // Result queue: {last_of_run, symbol}
  logic                   res_push;
  logic [SAMPLE_BITS:0]   res_wdata;
  logic                   res_full;
  logic                   res_pop;
  logic [SAMPLE_BITS:0]   res_rdata;
  logic                   res_empty;

  mmstr_done_t            done;

  assign cfg_chan.ready = 1'b1;

  // Take register writes at any time; the initial phase only matters at reset,
  // so accept its write and drop the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_omega_r <= NOMINAL_OMEGA_RST;
      omega_gain_r    <= OMEGA_GAIN_RST;
      phase_gain_r    <= PHASE_GAIN_RST;
      omega_limit_r   <= OMEGA_LIMIT_RST;
    end else if (cfg_chan.valid) begin
      unique case (mmstr_reg_t'(cfg_chan.index))
        REG_NOMINAL_OMEGA: nominal_omega_r <= cfg_chan.data[OMEGA_W-1:0];
        REG_OMEGA_GAIN:    omega_gain_r    <= cfg_chan.data[GAIN_W-1:0];
        REG_PHASE_GAIN:    phase_gain_r    <= cfg_chan.data[GAIN_W-1:0];
        REG_OMEGA_LIMIT:   omega_limit_r   <= cfg_chan.data[GAIN_W-1:0];
        REG_INITIAL_PHASE: ;
        default: ;
      endcase
    end
  end

  assign cfg.nominal_omega = nominal_omega_r;
  assign cfg.omega_gain    = omega_gain_r;
  assign cfg.phase_gain    = phase_gain_r;
  assign cfg.omega_limit   = omega_limit_r;

  // Intake: count down the skip and tag each sample
  mmstr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .done    (done)
  );

  mmstr_fifo #(
    .W     (SAMPLE_BITS + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // Symbol engine: window, interpolator and timing loop
  mmstr_back #(
    .TAPS        (TAPS),
    .PHASES      (PHASES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_wdata (res_wdata),
    .done      (done)
  );

  // Result queue decouples the engine from a stalled sink
  mmstr_fifo #(
    .W     (SAMPLE_BITS + 1),
    .DEPTH (RES_DEPTH)
  ) u_results (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (res_pop),
    .rdata (res_rdata),
    .empty (res_empty)
  );

  assign out_chan.valid       = !res_empty;
  assign out_chan.symbol      = res_rdata[SAMPLE_BITS-1:0];
  assign out_chan.last_of_run = res_rdata[SAMPLE_BITS];
  assign res_pop              = out_chan.valid && out_chan.ready;

`ifndef ASSERT_OFF
  // After a triggering sample is pushed the intake must drop its ready
  a_hold_after_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata[SAMPLE_BITS]) |=> !in_chan.ready)
    else $error("input taken right after a symbol trigger");

  // The run ends exactly with the transfer of a last-of-run result
  a_done_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    done.valid |-> (res_push && res_wdata[SAMPLE_BITS]))
    else $error("run end reported without a last-of-run result");

  // The engine never pushes into a full result queue
  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // The engine never pops an empty job queue
  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job queue underflow");
`endif

endmodule
